### hdl/twafh_pkg.sv
package twafh_pkg;

  localparam int unsigned HALF_W   = 16;
  localparam int unsigned WAIT_W   = 24;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ADDR_W   = 6;
  localparam int unsigned PULSE_W  = 6;
  localparam int unsigned CFG_W    = 24;

  localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd100;
  localparam logic [WAIT_W-1:0] TIMEOUT_RESET     = 24'd1000000;

  // configuration register indexes
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_TIMEOUT     = 1'b1;

  // pulse numbers within a frame
  localparam logic [PULSE_W-1:0] P_FIRST       = 6'd1;
  localparam logic [PULSE_W-1:0] P_SAMPLE_LAST = 6'd24;
  localparam logic [PULSE_W-1:0] P_ST0         = 6'd25;
  localparam logic [PULSE_W-1:0] P_END_SAMPLE  = 6'd27;
  localparam logic [PULSE_W-1:0] P_ADDR_FIRST  = 6'd30;
  localparam logic [PULSE_W-1:0] P_ADDR_LAST   = 6'd35;
  localparam logic [PULSE_W-1:0] P_DIR         = 6'd36;
  localparam logic [PULSE_W-1:0] P_GAP         = 6'd37;
  localparam logic [PULSE_W-1:0] P_DATA_FIRST  = 6'd38;
  localparam logic [PULSE_W-1:0] P_DATA_LAST   = 6'd45;
  localparam logic [PULSE_W-1:0] P_END_REG     = 6'd46;

  typedef enum logic [1:0] {
    CMD_NONE        = 2'd0,
    CMD_READ_SAMPLE = 2'd1,
    CMD_WRITE_REG   = 2'd2,
    CMD_READ_REG    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_HIGH = 2'd2,
    PH_LOW  = 2'd3
  } phase_t;

  typedef struct packed {
    logic                sck_level;
    logic                sda_out;
    logic                sda_drive;
    logic                busy;
    logic                done;
    logic                status;
    logic [SAMPLE_W-1:0] sample;
    logic                settings_applied;
    logic [BYTE_W-1:0]   read_data;
  } res_t;

endpackage

### hdl/twafh_seq.sv
module twafh_seq
  import twafh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  cmd_t              command,
  input  logic [ADDR_W-1:0] reg_addr,
  input  logic [BYTE_W-1:0] write_data,
  input  logic              sda_in,
  input  logic [HALF_W-1:0] half_period,
  input  logic [WAIT_W-1:0] timeout,
  output res_t              res
);

  phase_t                phase_r, phase_nxt;
  logic [PULSE_W-1:0]    pulse_r, pulse_nxt;
  logic [HALF_W-1:0]     half_r, half_nxt;
  logic [WAIT_W-1:0]     wait_r, wait_nxt;
  logic [SAMPLE_W-1:0]   sample_r, sample_nxt;
  logic [BYTE_W-1:0]     byte_r, byte_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [ADDR_W-1:0]     addr_r, addr_nxt;
  logic                  st0_r, st0_nxt;
  logic                  status_r, status_nxt;
  logic                  done;

  logic [HALF_W:0]       half_inc;
  logic [WAIT_W:0]       wait_inc;
  logic                  half_hit;
  logic [PULSE_W-1:0]    last_pulse;
  logic [PULSE_W-1:0]    drive_end;
  logic [PULSE_W-1:0]    addr_pos;

  assign half_inc   = {1'b0, half_r} + {{HALF_W{1'b0}}, 1'b1};
  assign wait_inc   = {1'b0, wait_r} + {{WAIT_W{1'b0}}, 1'b1};
  assign half_hit   = half_inc >= {1'b0, half_period};
  assign last_pulse = (cmd_r == CMD_READ_SAMPLE) ? P_END_SAMPLE : P_END_REG;

  always_comb begin
    phase_nxt  = phase_r;
    pulse_nxt  = pulse_r;
    half_nxt   = half_r;
    wait_nxt   = wait_r;
    sample_nxt = sample_r;
    byte_nxt   = byte_r;
    cmd_nxt    = cmd_r;
    addr_nxt   = addr_r;
    st0_nxt    = st0_r;
    status_nxt = status_r;
    done       = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (command != CMD_NONE) begin
          cmd_nxt   = command;
          addr_nxt  = reg_addr;
          byte_nxt  = (command == CMD_WRITE_REG) ? write_data : '0;
          wait_nxt  = '0;
          phase_nxt = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (!sda_in) begin
          sample_nxt = '0;
          pulse_nxt  = P_FIRST;
          half_nxt   = '0;
          phase_nxt  = PH_HIGH;
        end else if (wait_inc >= {1'b0, timeout}) begin
          status_nxt = 1'b1;
          phase_nxt  = PH_IDLE;
          done       = 1'b1;
        end else begin
          wait_nxt = wait_inc[WAIT_W-1:0];
        end
      end
      PH_HIGH: begin
        if (half_hit) begin
          // sda sampled on the last tick of the high phase
          if (pulse_r >= P_FIRST && pulse_r <= P_SAMPLE_LAST) begin
            sample_nxt = {sample_r[SAMPLE_W-2:0], sda_in};
          end else if (pulse_r == P_ST0) begin
            st0_nxt = sda_in;
          end else if (cmd_r == CMD_READ_REG && pulse_r >= P_DATA_FIRST &&
                       pulse_r <= P_DATA_LAST) begin
            byte_nxt = {byte_r[BYTE_W-2:0], sda_in};
          end
          half_nxt  = '0;
          phase_nxt = PH_LOW;
        end else begin
          half_nxt = half_inc[HALF_W-1:0];
        end
      end
      PH_LOW: begin
        if (half_hit) begin
          half_nxt = '0;
          if (cmd_r == CMD_WRITE_REG && pulse_r >= P_DATA_FIRST &&
              pulse_r <= P_DATA_LAST) begin
            byte_nxt = {byte_r[BYTE_W-2:0], 1'b0};
          end
          if (pulse_r >= last_pulse) begin
            status_nxt = 1'b0;
            pulse_nxt  = '0;
            phase_nxt  = PH_IDLE;
            done       = 1'b1;
          end else begin
            pulse_nxt = pulse_r + P_FIRST;
            phase_nxt = PH_HIGH;
          end
        end else begin
          half_nxt = half_inc[HALF_W-1:0];
        end
      end
    endcase
  end

  // pin levels and result fields follow the updated state
  assign drive_end = (cmd_nxt == CMD_WRITE_REG) ? P_DATA_LAST : P_DIR;
  assign addr_pos  = P_ADDR_LAST - pulse_nxt;

  always_comb begin
    res                  = '0;
    res.busy             = (phase_nxt != PH_IDLE);
    res.done             = done;
    res.status           = status_nxt;
    if (phase_nxt == PH_HIGH || phase_nxt == PH_LOW) begin
      res.sck_level = (phase_nxt == PH_HIGH);
      if (cmd_nxt != CMD_READ_SAMPLE && pulse_nxt >= P_ADDR_FIRST &&
          pulse_nxt <= drive_end) begin
        res.sda_drive = 1'b1;
        if (pulse_nxt <= P_ADDR_LAST) begin
          res.sda_out = addr_nxt[addr_pos[2:0]];
        end else if (pulse_nxt == P_DIR) begin
          res.sda_out = (cmd_nxt == CMD_WRITE_REG);
        end else if (pulse_nxt == P_GAP) begin
          res.sda_out = 1'b1;
        end else begin
          res.sda_out = byte_nxt[BYTE_W-1];
        end
      end
    end
    if (phase_nxt == PH_IDLE) begin
      res.sample           = sample_nxt;
      res.settings_applied = st0_nxt;
      res.read_data        = (cmd_nxt == CMD_READ_REG) ? byte_nxt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pulse_r  <= '0;
      half_r   <= '0;
      wait_r   <= '0;
      sample_r <= '0;
      byte_r   <= '0;
      cmd_r    <= CMD_NONE;
      addr_r   <= '0;
      st0_r    <= 1'b0;
      status_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      pulse_r  <= pulse_nxt;
      half_r   <= half_nxt;
      wait_r   <= wait_nxt;
      sample_r <= sample_nxt;
      byte_r   <= byte_nxt;
      cmd_r    <= cmd_nxt;
      addr_r   <= addr_nxt;
      st0_r    <= st0_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

### hdl/two_wire_adc_frame_host.sv
// two-wire adc frame host: pin-level sequencer for a two-wire pulse link
// in channel: one transaction per sequencer tick, carrying the sda pin level
//   and, when the host is idle, a command (none, read sample, write register,
//   read register) with its register address and write byte
// out channel: exactly one transaction per input transaction, giving the sck
//   and sda pin levels after that tick plus busy, status, the signed 24-bit
//   sample, st0 and the byte read back; out_tlast is the done pulse that marks
//   the tick on which a command ends
// config port: half period and timeout registers, written while idle; the
//   sequencer sees new values on the next accepted tick
// result: registered; it sits in the output register the cycle after its input
//   transaction is accepted
// throughput: one transaction per cycle unless stalled; each tick is one pass
//   through the sequencer next-state logic between the state and output registers
// stall: while the output register holds an untaken result, in_tready
//   follows out_tready, so the sequencer only advances on accepted ticks
// reset: sequencer idle, all counters, shift registers and status cleared,
//   config registers back to 100 ticks per phase and 1000000 ticks timeout,
//   output register empty
module two_wire_adc_frame_host
  import twafh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // config write port
  input  logic             cfg_wr_en,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  // input ticks
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [15:0]      in_tdata,   // reg_addr[5:0], write_data[13:6], sda_in[14], pad
  input  logic [1:0]       in_tuser,   // command[1:0]
  // results
  output logic             out_tvalid,
  input  logic             out_tready,
  // sck_level[0], sda_out[1], sda_drive[2], busy_res[3], status[4], sample[28:5],
  // settings_applied[29], read_data[37:30], pad[39:38]
  output logic [39:0]      out_tdata,
  output logic             out_tlast   // done_res
);

  logic [HALF_W-1:0] half_period_r;
  logic [WAIT_W-1:0] timeout_r;
  logic              out_valid_r;
  res_t              out_res_r;
  res_t              res;
  logic              in_accept;

  // output register frees up when empty or being taken this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RESET;
      timeout_r     <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_HALF_PERIOD: half_period_r <= cfg_wdata[HALF_W-1:0];
        REG_TIMEOUT:     timeout_r     <= cfg_wdata[WAIT_W-1:0];
      endcase
    end
  end

  twafh_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_accept),
    .command     (cmd_t'(in_tuser)),
    .reg_addr    (in_tdata[5:0]),
    .write_data  (in_tdata[13:6]),
    .sda_in      (in_tdata[14]),
    .half_period (half_period_r),
    .timeout     (timeout_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload register, loaded with each accepted tick
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.read_data, out_res_r.settings_applied,
                       out_res_r.sample, out_res_r.status,
                       out_res_r.busy, out_res_r.sda_drive, out_res_r.sda_out,
                       out_res_r.sck_level};
  assign out_tlast  = out_res_r.done;

endmodule
